// ----- sv/cbad_pkg.sv -----
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types, codes and decode constants for the CPU bus address decoder.
// ----------------------------------------------------------------------------
package cbad_pkg;

  // Default sizes
  localparam int RAM_BYTES_DEF      = 2048;
  localparam int ROM_BANK_BYTES_DEF = 16384;

  // Bus access codes
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FWD   = 2'd1,
    ST_FATAL = 2'd2
  } status_t;

  // Where the read byte of a beat comes from
  typedef enum logic [1:0] {
    SRC_VALUE = 2'd0,
    SRC_RAM   = 2'd1,
    SRC_ROM   = 2'd2
  } rd_src_t;

  // Video register numbers with special handling
  localparam logic [2:0] VREG_STATUS   = 3'd2;
  localparam logic [2:0] VREG_OAM_DATA = 3'd4;
  localparam logic [2:0] VREG_ADDR     = 3'd6;
  localparam logic [2:0] VREG_DATA     = 3'd7;

  localparam int          VREG_SLOTS = 6;
  localparam logic [15:0] DMA_PORT   = 16'h4014;

  // Storage slot of a plain video register (0,1,3,4,5,7 map to 0..5)
  function automatic logic [2:0] vreg_slot(input logic [2:0] num);
    logic [2:0] slot;
    case (num)
      3'd0:    slot = 3'd0;
      3'd1:    slot = 3'd1;
      3'd3:    slot = 3'd2;
      3'd4:    slot = 3'd3;
      3'd5:    slot = 3'd4;
      3'd7:    slot = 3'd5;
      default: slot = 3'd0;
    endcase
    return slot;
  endfunction

endpackage

// ----- sv/cbad_in_if.sv -----
// ----------------------------------------------------------------------------
// cbad_in_if
// Bus access channel: valid/ready handshake with opcode, address and data.
// ----------------------------------------------------------------------------
interface cbad_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output opcode, output address, output write_data,
                  input ready);
  modport sink   (input valid, input opcode, input address, input write_data,
                  output ready);
endinterface

// ----- sv/cbad_out_if.sv -----
// ----------------------------------------------------------------------------
// cbad_out_if
// Result channel: valid/ready handshake with read byte, status and state.
// ----------------------------------------------------------------------------
interface cbad_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic [1:0]  status;
  logic [2:0]  forwarded_register;
  logic [15:0] video_address;
  logic        fatal_flag;

  modport source (output valid, output read_data, output status,
                  output forwarded_register, output video_address, output fatal_flag,
                  input ready);
  modport sink   (input valid, input read_data, input status,
                  input forwarded_register, input video_address, input fatal_flag,
                  output ready);
endinterface

// ----- sv/cpu_bus_address_decoder.sv -----
// ----------------------------------------------------------------------------
// cpu_bus_address_decoder
// Decodes CPU bus beats onto work RAM, two program ROM banks, the video
// registers and the DMA page port.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus carries one bus access per beat (read, write, ROM load or no-op);
//   out_bus returns exactly one result beat per access, in order.
//   The pipeline is: input register (quotient multiply for the RAM/ROM
//   folding in front of it), then memory read and state update into the
//   second register, then read-data select into the output register. One
//   beat is taken every cycle while out_bus.ready is high; throughput is
//   set by the single read port of each memory, used once per beat.
//   When out_bus stalls, the whole pipeline holds and in_bus.ready drops in
//   the same cycle; no beat is lost or repeated.
//   Reset (rst_n low, synchronous) empties the pipeline and clears the video
//   registers, DMA page, bus latch, video address and fatal flag; the video
//   address write order starts with the high byte. Work RAM and program ROM
//   keep no reset and must be written before they are read.
// ----------------------------------------------------------------------------
module cpu_bus_address_decoder
  import cbad_pkg::*;
#(
  parameter int RAM_BYTES      = RAM_BYTES_DEF,
  parameter int ROM_BANK_BYTES = ROM_BANK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cbad_in_if.sink     in_bus,
  cbad_out_if.source  out_bus
);

  localparam int RAM_AW   = $clog2(RAM_BYTES);
  localparam int ROM_TOT  = 2 * ROM_BANK_BYTES;
  localparam int ROM_AW   = $clog2(ROM_TOT);

  // Exact reciprocals: floor(x*M >> SH) == x / C for every x of the width
  localparam int RAM_SH = 13 + $clog2(RAM_BYTES);
  localparam int ROM_SH = 14 + $clog2(ROM_BANK_BYTES);
  localparam int LD_SH  = 16 + $clog2(ROM_TOT);
  localparam logic [13:0] RAM_M =
    14'(((64'd1 << RAM_SH) + 64'(RAM_BYTES) - 64'd1) / 64'(RAM_BYTES));
  localparam logic [15:0] ROM_M =
    16'(((64'd1 << ROM_SH) + 64'(ROM_BANK_BYTES) - 64'd1) / 64'(ROM_BANK_BYTES));
  localparam logic [17:0] LD_M =
    18'(((64'd1 << LD_SH) + 64'(ROM_TOT) - 64'd1) / 64'(ROM_TOT));
  localparam logic [12:0] RAM_C13 = 13'(RAM_BYTES);
  localparam logic [13:0] ROM_C14 = 14'(ROM_BANK_BYTES);
  localparam logic [15:0] ROM_C16 = 16'(ROM_BANK_BYTES);
  localparam logic [15:0] LD_C16  = 16'(ROM_TOT);

  // Pipeline control
  logic advance;
  logic accept;
  logic go;

  // Stage 1: accepted beat with its quotients
  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [15:0] s1_addr_r;
  logic [7:0]  s1_data_r;
  logic [12:0] s1_ram_q_r;
  logic [13:0] s1_rom_q_r;
  logic [15:0] s1_ld_q_r;

  logic [26:0] ram_prod;
  logic [29:0] rom_prod;
  logic [33:0] ld_prod;

  // Block state
  logic [7:0]  vregs_r [VREG_SLOTS];
  logic [7:0]  dma_r, dma_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic [15:0] vptr_r, vptr_nxt;
  logic        hi_r, hi_nxt;
  logic        fatal_r, fatal_nxt;
  logic        vreg_we;

  // Stage 1 decode results
  logic [12:0]       ram_off;
  logic [13:0]       rom_off;
  logic [15:0]       rom_rd16;
  logic [15:0]       ld_off;
  logic [RAM_AW-1:0] ram_idx;
  logic [ROM_AW-1:0] rom_ridx;
  logic [ROM_AW-1:0] rom_widx;
  logic              ram_we, ram_re, rom_we, rom_re;
  logic [2:0]        vreg_num;
  status_t           st;
  logic [2:0]        fwd;
  rd_src_t           src;
  logic [7:0]        val;

  // Stage 2: memory data arriving
  logic        s2_valid_r;
  rd_src_t     s2_src_r;
  logic [7:0]  s2_val_r;
  status_t     s2_status_r;
  logic [2:0]  s2_fwd_r;
  logic [15:0] s2_vaddr_r;
  logic        s2_fatal_r;
  logic [7:0]  ram_rdata, rom_rdata;
  logic [7:0]  s2_rd;

  // Output register
  logic        out_valid_r;
  logic [7:0]  out_rd_r;
  status_t     out_status_r;
  logic [2:0]  out_fwd_r;
  logic [15:0] out_vaddr_r;
  logic        out_fatal_r;

  // Advance all stages together unless the result is stalled
  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = advance;
  assign accept       = in_bus.valid && advance;
  assign go           = s1_valid_r && advance;

  // Quotients for the RAM mirror, ROM bank window and ROM load folding
  assign ram_prod = 27'(in_bus.address[12:0]) * 27'(RAM_M);
  assign rom_prod = 30'(in_bus.address[13:0]) * 30'(ROM_M);
  assign ld_prod  = 34'(in_bus.address) * 34'(LD_M);

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_t'(in_bus.opcode);
      s1_addr_r  <= in_bus.address;
      s1_data_r  <= in_bus.write_data;
      s1_ram_q_r <= 13'(ram_prod >> RAM_SH);
      s1_rom_q_r <= 14'(rom_prod >> ROM_SH);
      s1_ld_q_r  <= 16'(ld_prod >> LD_SH);
    end
  end

  // Finish the remainders into memory indexes
  assign ram_off  = s1_addr_r[12:0] - 13'(s1_ram_q_r * RAM_C13);
  assign rom_off  = s1_addr_r[13:0] - 14'(s1_rom_q_r * ROM_C14);
  assign rom_rd16 = s1_addr_r[14] ? (ROM_C16 + 16'(rom_off)) : 16'(rom_off);
  assign ld_off   = s1_addr_r - 16'(s1_ld_q_r * LD_C16);
  assign ram_idx  = RAM_AW'(ram_off);
  assign rom_ridx = ROM_AW'(rom_rd16);
  assign rom_widx = ROM_AW'(ld_off);
  assign vreg_num = s1_addr_r[2:0];

  // Decode the beat: state updates and result fields
  always_comb begin
    dma_nxt   = dma_r;
    latch_nxt = latch_r;
    vptr_nxt  = vptr_r;
    hi_nxt    = hi_r;
    fatal_nxt = fatal_r;
    vreg_we   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    rom_we    = 1'b0;
    rom_re    = 1'b0;
    st        = ST_OK;
    fwd       = 3'd0;
    src       = SRC_VALUE;
    val       = 8'd0;
    unique case (s1_op_r)
      OP_READ: begin
        if (s1_addr_r[15]) begin
          src    = SRC_ROM;
          rom_re = 1'b1;
        end else if (s1_addr_r[15:13] == 3'b000) begin
          src    = SRC_RAM;
          ram_re = 1'b1;
        end else if (s1_addr_r[15:13] == 3'b001) begin
          case (vreg_num) inside
            VREG_STATUS, VREG_OAM_DATA, VREG_DATA: begin
              st  = ST_FWD;
              fwd = vreg_num;
            end
            default: val = latch_r;
          endcase
        end else if (s1_addr_r == DMA_PORT) begin
          val = dma_r;
        end else begin
          st        = ST_FATAL;
          fatal_nxt = 1'b1;
        end
      end
      OP_WRITE: begin
        if (s1_addr_r[15]) begin
          st        = ST_FATAL;
          fatal_nxt = 1'b1;
        end else if (s1_addr_r[15:13] == 3'b000) begin
          ram_we = 1'b1;
        end else if (s1_addr_r[15:13] == 3'b001) begin
          if (vreg_num == VREG_ADDR) begin
            vptr_nxt = hi_r ? {s1_data_r, vptr_r[7:0]} : {vptr_r[15:8], s1_data_r};
            hi_nxt   = !hi_r;
          end else if (vreg_num != VREG_STATUS) begin
            vreg_we = 1'b1;
          end
          latch_nxt = s1_data_r;
        end else if (s1_addr_r == DMA_PORT) begin
          dma_nxt   = s1_data_r;
          latch_nxt = s1_data_r;
        end
      end
      OP_LOAD: begin
        rom_we = 1'b1;
      end
      OP_NOP: begin
      end
    endcase
  end

  // Update block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VREG_SLOTS; i++) begin
        vregs_r[i] <= 8'd0;
      end
      dma_r   <= 8'd0;
      latch_r <= 8'd0;
      vptr_r  <= 16'd0;
      hi_r    <= 1'b1;
      fatal_r <= 1'b0;
    end else if (go) begin
      if (vreg_we) begin
        vregs_r[vreg_slot(vreg_num)] <= s1_data_r;
      end
      dma_r   <= dma_nxt;
      latch_r <= latch_nxt;
      vptr_r  <= vptr_nxt;
      hi_r    <= hi_nxt;
      fatal_r <= fatal_nxt;
    end
  end

  // Work RAM and program ROM
  cbad_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_work_ram (
    .clk   (clk),
    .we    (go && ram_we),
    .waddr (ram_idx),
    .wdata (s1_data_r),
    .re    (go && ram_re),
    .raddr (ram_idx),
    .rdata (ram_rdata)
  );

  cbad_ram #(.WIDTH(8), .DEPTH(ROM_TOT)) u_prog_rom (
    .clk   (clk),
    .we    (go && rom_we),
    .waddr (rom_widx),
    .wdata (s1_data_r),
    .re    (go && rom_re),
    .raddr (rom_ridx),
    .rdata (rom_rdata)
  );

  // Advance the result fields alongside the memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      s2_src_r    <= src;
      s2_val_r    <= val;
      s2_status_r <= st;
      s2_fwd_r    <= fwd;
      s2_vaddr_r  <= vptr_nxt;
      s2_fatal_r  <= fatal_nxt;
    end
  end

  // Select the read byte
  always_comb begin
    case (s2_src_r)
      SRC_RAM: s2_rd = ram_rdata;
      SRC_ROM: s2_rd = rom_rdata;
      default: s2_rd = s2_val_r;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s2_valid_r) begin
      out_rd_r     <= s2_rd;
      out_status_r <= s2_status_r;
      out_fwd_r    <= s2_fwd_r;
      out_vaddr_r  <= s2_vaddr_r;
      out_fatal_r  <= s2_fatal_r;
    end
  end

  assign out_bus.valid              = out_valid_r;
  assign out_bus.read_data          = out_rd_r;
  assign out_bus.status             = out_status_r;
  assign out_bus.forwarded_register = out_fwd_r;
  assign out_bus.video_address      = out_vaddr_r;
  assign out_bus.fatal_flag         = out_fatal_r;

  // Fatal flag never clears once set
  a_fatal_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    fatal_r |=> fatal_r)
    else $error("fatal flag cleared");

  // Fatal flag only rises when a beat is decoded
  a_fatal_cause : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fatal_r) |-> $past(go))
    else $error("fatal flag set without a beat");

  // A fatal result always reports the flag
  a_fatal_result : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FATAL) |-> out_fatal_r)
    else $error("fatal status without fatal flag");

  // A forwarded read returns no data
  a_fwd_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r == ST_FWD) |-> (out_rd_r == 8'd0))
    else $error("forwarded read carries data");

  // Stalled result holds the whole pipeline
  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> ($stable(s1_valid_r) && $stable(s2_valid_r)))
    else $error("pipeline moved under stall");

endmodule

// ----- sv/cbad_ram.sv -----
// ----------------------------------------------------------------------------
// cbad_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cbad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
